>>> sv/mau_pkg.sv
// package for the modular arithmetic unit: modulus constants, field types,
// microcode control word layout and the microcode program rom
// no dependencies; used by mau_mulmod and modular_arith_unit_top
package mau_pkg;

	// field widths
	localparam int unsigned A_W = 30;
	localparam int unsigned B_W = 32;

	// modulus and derived constants
	localparam logic [29:0] MODULUS  = 30'd1000000007;
	localparam logic [31:0] MOD_32   = {2'b00, MODULUS};
	localparam logic [31:0] MOD2_32  = {1'b0, MODULUS, 1'b0};
	// barrett factor floor(2^60 / modulus)
	localparam logic [63:0] MU_WIDE  = (64'd1 << 60) / 64'd1000000007;
	localparam logic [30:0] MU       = MU_WIDE[30:0];

	// operation selector
	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_POW = 2'd3
	} func_t;

	// microcode addresses
	typedef enum logic [3:0] {
		S_DISP  = 4'd0,
		S_ADD   = 4'd1,
		S_SUB   = 4'd2,
		S_MUL   = 4'd3,
		S_MW1   = 4'd4,
		S_MW2   = 4'd5,
		S_MW3   = 4'd6,
		S_MULWB = 4'd7,
		S_PTOP  = 4'd8,
		S_PACC  = 4'd9,
		S_PW1   = 4'd10,
		S_PW2   = 4'd11,
		S_PBASE = 4'd12,
		S_PSTEP = 4'd13,
		S_PDONE = 4'd14,
		S_ERR   = 4'd15
	} upc_t;

	// multiplier operand pair
	typedef enum logic [1:0] {
		MUL_NONE = 2'd0,
		MUL_AB   = 2'd1,
		MUL_SQ   = 2'd2,
		MUL_ACC  = 2'd3
	} mul_sel_t;

	// result source; anything but none finishes the item
	typedef enum logic [2:0] {
		RES_NONE = 3'd0,
		RES_ADD  = 3'd1,
		RES_SUB  = 3'd2,
		RES_MUL  = 3'd3,
		RES_ACC  = 3'd4,
		RES_ZERO = 3'd5
	} res_sel_t;

	// sequencing condition
	typedef enum logic [1:0] {
		COND_NEXT     = 2'd0,
		COND_JUMP     = 2'd1,
		COND_EXP_ZERO = 2'd2,
		COND_DISPATCH = 2'd3
	} cond_t;

	// one microcode control word
	typedef struct packed {
		mul_sel_t mul_sel;
		logic     wb_base;
		logic     wb_acc_odd;
		logic     shift_exp;
		res_sel_t res_sel;
		cond_t    cond;
		upc_t     target;
	} ucw_t;

	// control into the modular multiplier
	typedef struct packed {
		logic en;
		logic issue;
	} mm_req_t;

	// response from the modular multiplier
	typedef struct packed {
		logic        vld;
		logic [29:0] r;
	} mm_rsp_t;

	localparam ucw_t UCW_NOP = '{
		mul_sel: MUL_NONE, wb_base: 1'b0, wb_acc_odd: 1'b0, shift_exp: 1'b0,
		res_sel: RES_NONE, cond: COND_NEXT, target: S_DISP};

	// microcode program; wait steps lie between each multiplier issue and the step that reads its result
	function automatic ucw_t ucode_rom(upc_t pc);
		ucw_t cw;
		cw = UCW_NOP;
		unique case (pc)
			S_DISP: begin
				cw.cond = COND_DISPATCH;
			end
			S_ADD: begin
				cw.res_sel = RES_ADD;
				cw.cond    = COND_JUMP;
			end
			S_SUB: begin
				cw.res_sel = RES_SUB;
				cw.cond    = COND_JUMP;
			end
			S_MUL: begin
				cw.mul_sel = MUL_AB;
			end
			S_MW1, S_MW2, S_MW3, S_PW1, S_PW2: begin
				cw.cond = COND_NEXT;
			end
			S_MULWB: begin
				cw.res_sel = RES_MUL;
				cw.cond    = COND_JUMP;
			end
			S_PTOP: begin
				cw.mul_sel = MUL_SQ;
				cw.cond    = COND_EXP_ZERO;
				cw.target  = S_PDONE;
			end
			S_PACC: begin
				cw.mul_sel = MUL_ACC;
			end
			S_PBASE: begin
				cw.wb_base = 1'b1;
			end
			S_PSTEP: begin
				cw.wb_acc_odd = 1'b1;
				cw.shift_exp  = 1'b1;
				cw.cond       = COND_JUMP;
				cw.target     = S_PTOP;
			end
			S_PDONE: begin
				cw.res_sel = RES_ACC;
				cw.cond    = COND_JUMP;
			end
			S_ERR: begin
				cw.res_sel = RES_ZERO;
				cw.cond    = COND_JUMP;
			end
		endcase
		return cw;
	endfunction

endpackage

>>> sv/mau_mulmod.sv
// four-stage modular multiplier: 30x30 product, barrett reduction by the
// modulus and a final correction that subtracts twice the modulus or the modulus
// depends on mau_pkg
module mau_mulmod (
	input  logic               clk,
	input  logic               arst_n,
	input  mau_pkg::mm_req_t   req,
	input  logic [29:0]        x,
	input  logic [29:0]        y,
	output mau_pkg::mm_rsp_t   rsp
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [59:0] prod_c;
	logic [59:0] prod_s1;
	logic [61:0] q2_c;
	logic [61:0] q2_s2;
	logic [31:0] xlo_s2, xlo_s3;
	logic [60:0] qp_c;
	logic [31:0] qp_s3;
	logic [31:0] rr_c;
	logic [29:0] rfix_c;
	logic [29:0] r_s4;

	// stage arithmetic
	assign prod_c = x * y;
	assign q2_c   = prod_s1[59:29] * mau_pkg::MU;
	assign qp_c   = q2_s2[61:31] * mau_pkg::MODULUS;
	assign rr_c   = xlo_s3 - qp_s3;

	// remainder is below three times the modulus here
	always_comb begin
		priority if (rr_c >= mau_pkg::MOD2_32) begin
			rfix_c = 30'(rr_c - mau_pkg::MOD2_32);
		end else if (rr_c >= mau_pkg::MOD_32) begin
			rfix_c = 30'(rr_c - mau_pkg::MOD_32);
		end else begin
			rfix_c = rr_c[29:0];
		end
	end

	// valid track
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (req.en) begin
			v_s1 <= req.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// data pipeline
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_s1 <= prod_c;
			q2_s2   <= q2_c;
			xlo_s2  <= prod_s1[31:0];
			qp_s3   <= qp_c[31:0];
			xlo_s3  <= xlo_s2;
			r_s4    <= rfix_c;
		end
	end

	assign rsp.vld = v_s4;
	assign rsp.r   = r_s4;

	// a finished product is always a reduced residue
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (r_s4 < mau_pkg::MODULUS))
		else $error("modular product not reduced");

endmodule

>>> sv/modular_arith_unit_top.sv
// Arithmetic unit modulo 1000000007. Each input transaction carries an operation
// (add, subtract, multiply, power) and two operands; each gives one output
// transaction with the residue and an operand error flag (result 0 on error).
// A microcoded sequencer drives a four-stage modular multiplier. Add, subtract and
// operand errors need no product, multiply waits for one product, and power runs
// square-and-multiply over the exponent bits up to the highest set one, with a square
// and an accumulator multiply for each bit. A new item is taken once the previous
// one sits in the output register, so input and output overlap.
// depends on mau_pkg and mau_mulmod
module modular_arith_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // operand_a [29:0], operand_b [61:30], zero [63:62]
	input  logic [1:0]  s_tuser,   // func [1:0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result [29:0], zero [31:30]
	output logic [0:0]  m_tuser    // operand_error [0]
);

	logic                 accept;
	logic                 busy_q;
	mau_pkg::upc_t        pc_q, pc_nxt;
	mau_pkg::ucw_t        cw;
	logic                 done, adv;
	logic [29:0]          in_a;
	logic [31:0]          in_b;
	mau_pkg::func_t       in_func;
	logic                 in_err;
	mau_pkg::func_t       func_q;
	logic                 err_q;
	logic [29:0]          base_q, acc_q;
	logic [31:0]          exp_q;
	logic [29:0]          b30;
	logic [30:0]          sum_c;
	logic [29:0]          add_r, sub_r;
	logic [29:0]          res_val;
	logic [29:0]          mx, my;
	mau_pkg::mm_req_t     mm_req;
	mau_pkg::mm_rsp_t     mm_rsp;
	logic [29:0]          res_q;
	logic                 oerr_q;
	logic                 out_vld_q;

	// input unpacking and operand check
	assign in_a    = s_tdata[29:0];
	assign in_b    = s_tdata[61:30];
	assign in_func = mau_pkg::func_t'(s_tuser);
	assign in_err  = (in_a >= mau_pkg::MODULUS) ||
		((in_func != mau_pkg::FUNC_POW) && (in_b >= mau_pkg::MOD_32));

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;

	// microcode fetch and stall control
	assign cw   = mau_pkg::ucode_rom(pc_q);
	assign done = busy_q && (cw.res_sel != mau_pkg::RES_NONE);
	assign adv  = busy_q && (!done || !out_vld_q || m_tready);

	// next step address
	always_comb begin
		unique case (cw.cond)
			mau_pkg::COND_NEXT: begin
				pc_nxt = mau_pkg::upc_t'(pc_q + 4'd1);
			end
			mau_pkg::COND_JUMP: begin
				pc_nxt = cw.target;
			end
			mau_pkg::COND_EXP_ZERO: begin
				pc_nxt = (exp_q == 32'd0) ? cw.target : mau_pkg::upc_t'(pc_q + 4'd1);
			end
			mau_pkg::COND_DISPATCH: begin
				if (err_q) begin
					pc_nxt = mau_pkg::S_ERR;
				end else begin
					unique case (func_q)
						mau_pkg::FUNC_ADD: pc_nxt = mau_pkg::S_ADD;
						mau_pkg::FUNC_SUB: pc_nxt = mau_pkg::S_SUB;
						mau_pkg::FUNC_MUL: pc_nxt = mau_pkg::S_MUL;
						mau_pkg::FUNC_POW: pc_nxt = mau_pkg::S_PTOP;
					endcase
				end
			end
		endcase
	end

	// add and subtract with one correction
	assign b30   = exp_q[29:0];
	assign sum_c = {1'b0, base_q} + {1'b0, b30};
	assign add_r = (sum_c >= {1'b0, mau_pkg::MODULUS}) ?
		30'(sum_c - {1'b0, mau_pkg::MODULUS}) : sum_c[29:0];
	assign sub_r = (base_q < b30) ?
		30'({1'b0, base_q} + {1'b0, mau_pkg::MODULUS} - {1'b0, b30}) : (base_q - b30);

	// result source
	always_comb begin
		unique case (cw.res_sel)
			mau_pkg::RES_ADD: res_val = add_r;
			mau_pkg::RES_SUB: res_val = sub_r;
			mau_pkg::RES_MUL: res_val = mm_rsp.r;
			mau_pkg::RES_ACC: res_val = acc_q;
			default:          res_val = 30'd0;
		endcase
	end

	// multiplier operands
	always_comb begin
		unique case (cw.mul_sel)
			mau_pkg::MUL_AB: begin
				mx = base_q;
				my = b30;
			end
			mau_pkg::MUL_SQ: begin
				mx = base_q;
				my = base_q;
			end
			mau_pkg::MUL_ACC: begin
				mx = acc_q;
				my = base_q;
			end
			mau_pkg::MUL_NONE: begin
				mx = 30'd0;
				my = 30'd0;
			end
		endcase
	end

	assign mm_req.en    = adv;
	assign mm_req.issue = busy_q && (cw.mul_sel != mau_pkg::MUL_NONE);

	mau_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.x      (mx),
		.y      (my),
		.rsp    (mm_rsp)
	);

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pc_q      <= mau_pkg::S_DISP;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= mau_pkg::S_DISP;
			end else if (adv) begin
				pc_q <= pc_nxt;
				if (done) begin
					busy_q <= 1'b0;
				end
			end
			if (adv && done) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= in_func;
			err_q  <= in_err;
			base_q <= in_a;
			acc_q  <= 30'd1;
			exp_q  <= in_b;
		end else if (adv) begin
			if (cw.wb_base) begin
				base_q <= mm_rsp.r;
			end
			if (cw.wb_acc_odd && exp_q[0]) begin
				acc_q <= mm_rsp.r;
			end
			if (cw.shift_exp) begin
				exp_q <= exp_q >> 1;
			end
		end
		if (adv && done) begin
			res_q  <= res_val;
			oerr_q <= err_q;
		end
	end

	// output transaction
	assign m_tvalid   = out_vld_q;
	assign m_tdata    = {2'b00, res_q};
	assign m_tuser[0] = oerr_q;

	// results are residues
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (res_q < mau_pkg::MODULUS))
		else $error("result not below modulus");

	// an operand error always gives a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && oerr_q) |-> (res_q == 30'd0))
		else $error("operand error with nonzero result");

	// microcode reads the multiplier only when a product is due
	a_mul_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (cw.wb_base || cw.wb_acc_odd || (cw.res_sel == mau_pkg::RES_MUL)))
		|-> mm_rsp.vld)
		else $error("multiplier result used before it is ready");

	// an accepted item starts the program at dispatch
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && (pc_q == mau_pkg::S_DISP)))
		else $error("sequencer did not start on accepted item");

endmodule
